/* hw/rtl/vn3d_pkg.sv */
// ----------------------------------------------------------------------------
// vn3d_pkg
// Shared widths and constants for the 3D value noise pipeline.
// ----------------------------------------------------------------------------
package vn3d_pkg;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned CoordW    = 32;
  localparam int unsigned IdxW      = 32;
  localparam int unsigned ValW      = 32;
  localparam int unsigned WeightW   = FracBits + 1;

  localparam logic [IdxW-1:0] StrideY  = 32'd400;
  localparam logic [IdxW-1:0] StrideZ  = 32'd160000;
  localparam logic [31:0]     HashMulA = 32'd15731;
  localparam logic [31:0]     HashAddA = 32'd789221;
  localparam logic [31:0]     HashAddB = 32'd1376312589;
  localparam logic [31:0]     HashMask = 32'h7fffffff;
  localparam logic [31:0]     HashOne  = 32'h40000000;

  typedef logic [WeightW-1:0] weight_t;
  typedef logic signed [ValW-1:0] val_t;

endpackage

/* hw/rtl/vn3d_hash.sv */
// ----------------------------------------------------------------------------
// vn3d_hash
// Corner hash over four register stages: shift-xor, square, second product,
// final product and offset to a Q2.30 corner value.
// ----------------------------------------------------------------------------
module vn3d_hash (
  input  logic                           clk_i,
  input  logic [vn3d_pkg::IdxW-1:0]      idx_i,
  output vn3d_pkg::val_t                 val_o
);

  logic [31:0] a_q, a1_q, a2_q, sq_q, m_q, h_q;
  logic [31:0] a_d;

  assign a_d = idx_i ^ (idx_i << 13);

  always_ff @(posedge clk_i) begin
    a_q  <= a_d;
    sq_q <= a_q * a_q;
    a1_q <= a_q;
    m_q  <= sq_q * vn3d_pkg::HashMulA + vn3d_pkg::HashAddA;
    a2_q <= a1_q;
    h_q  <= a2_q * m_q + vn3d_pkg::HashAddB;
  end

  assign val_o = vn3d_pkg::val_t'(vn3d_pkg::HashOne - (h_q & vn3d_pkg::HashMask));

endmodule

/* hw/rtl/vn3d_smooth.sv */
// ----------------------------------------------------------------------------
// vn3d_smooth
// Smoothstep of the fraction bits; f*f and 3-2f are registered.
// ----------------------------------------------------------------------------
module vn3d_smooth (
  input  logic                            clk_i,
  input  logic [vn3d_pkg::FracBits-1:0]   frac_i,
  output vn3d_pkg::weight_t               s_o
);

  localparam int unsigned F = vn3d_pkg::FracBits;

  logic [2*F-1:0] fsq;
  logic [F:0]     sq_q;
  logic [F+1:0]   k_q;
  logic [2*F+2:0] prod;

  assign fsq  = frac_i * frac_i;
  assign prod = sq_q * k_q + (2*F+3)'(1 << (F-1));

  always_ff @(posedge clk_i) begin
    sq_q <= (F+1)'((fsq + (2*F)'(1 << (F-1))) >> F);
    k_q  <= (F+2)'(3 << F) - {frac_i, 1'b0};
  end

  assign s_o = vn3d_pkg::weight_t'(prod >> F);

endmodule

/* hw/rtl/vn3d_lerp.sv */
// ----------------------------------------------------------------------------
// vn3d_lerp
// Registered linear blend p*(1-s) + q*s with rounding and floor shift.
// ----------------------------------------------------------------------------
module vn3d_lerp (
  input  logic                clk_i,
  input  vn3d_pkg::val_t      p_i,
  input  vn3d_pkg::val_t      q_i,
  input  vn3d_pkg::weight_t   s_i,
  output vn3d_pkg::val_t      r_o
);

  localparam int unsigned F = vn3d_pkg::FracBits;
  localparam int unsigned W = vn3d_pkg::ValW + F + 3;

  logic signed [F+1:0] s_s, w_s;
  logic signed [W-1:0] pw_q, qs_q, sum;

  assign s_s = $signed({1'b0, s_i});
  assign w_s = $signed((F+2)'(1 << F)) - s_s;
  assign sum = pw_q + qs_q + W'(1 << (F-1));

  // widen before the product so nothing is lost at 32 bits
  always_ff @(posedge clk_i) begin
    pw_q <= W'(p_i) * W'(w_s);
    qs_q <= W'(q_i) * W'(s_s);
  end

  // arithmetic shift is the floor
  assign r_o = vn3d_pkg::val_t'(sum >>> F);

endmodule

/* hw/rtl/value_noise_3d_smoothstep_core.sv */
// ----------------------------------------------------------------------------
// value_noise_3d_smoothstep_core
// 3D value noise: lattice hash at eight corners, smoothstep weights,
// trilinear blend to a Q2.30 sample.
// ----------------------------------------------------------------------------
// Usage: drive x/y/z_coord_i (signed 16.16) and pulse start_i; a point is
// taken on any edge with start_i high and busy_o low. busy_o is always low,
// so a point may enter every cycle. Each sample appears on noise_value_o for
// one cycle with done_o high, once its point has passed twelve register stages
// (the first loaded at the accepting edge), in order.
// Throughput is one sample per cycle, since every stage is fully pipelined;
// the hash multiplier chain (4 stages) and three blend levels (2 stages each)
// follow the index fold.
// Stage layout: 2 index fold (stride products, sum), 4 hash (corner offsets
// ahead of the first), 2 lerp x, 2 lerp y, 2 lerp z (weights travel
// alongside in delay lines).
// The receiver cannot stall; results are never held. Reset clears the valid
// pipeline only, so no spurious done_o follows reset.
// ----------------------------------------------------------------------------
module value_noise_3d_smoothstep_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  output logic                 busy_o,
  input  logic signed [31:0]   x_coord_i,
  input  logic signed [31:0]   y_coord_i,
  input  logic signed [31:0]   z_coord_i,
  output logic                 done_o,
  output logic signed [31:0]   noise_value_o
);

  localparam int unsigned F    = vn3d_pkg::FracBits;
  localparam int unsigned Lat  = 12;

  logic [Lat-1:0] vld_q;
  logic           take;

  assign busy_o = 1'b0;
  assign take   = start_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], take};
    end
  end

  // stages 1 and 2: fold integer parts (floor values times strides, then the sum)
  logic [31:0] xi, yi, zi;
  logic [31:0] ix_q, iy_q, iz_q, idx_q;
  assign xi = 32'($signed(x_coord_i[31:F]));
  assign yi = 32'($signed(y_coord_i[31:F]));
  assign zi = 32'($signed(z_coord_i[31:F]));

  always_ff @(posedge clk_i) begin
    ix_q  <= xi;
    iy_q  <= yi * vn3d_pkg::StrideY;
    iz_q  <= zi * vn3d_pkg::StrideZ;
    idx_q <= ix_q + iy_q + iz_q;
  end

  // corner offsets into eight hash pipes
  logic [31:0] cidx [8];
  vn3d_pkg::val_t cval [8];
  always_comb begin
    for (int c = 0; c < 8; c++) begin
      cidx[c] = idx_q + (c[0] ? 32'd1 : 32'd0)
                      + (c[1] ? vn3d_pkg::StrideY : 32'd0)
                      + (c[2] ? vn3d_pkg::StrideZ : 32'd0);
    end
  end

  for (genvar c = 0; c < 8; c++) begin : g_hash
    vn3d_hash u_hash (.clk_i(clk_i), .idx_i(cidx[c]), .val_o(cval[c]));
  end

  // weights: smoothstep then delay to each lerp level
  vn3d_pkg::weight_t sx, sy, sz;
  vn3d_smooth u_sx (.clk_i(clk_i), .frac_i(x_coord_i[F-1:0]), .s_o(sx));
  vn3d_smooth u_sy (.clk_i(clk_i), .frac_i(y_coord_i[F-1:0]), .s_o(sy));
  vn3d_smooth u_sz (.clk_i(clk_i), .frac_i(z_coord_i[F-1:0]), .s_o(sz));

  // sx, sy and sz are delayed so each meets its lerp level with its point's corners
  vn3d_pkg::weight_t sx_q [5];
  vn3d_pkg::weight_t sy_q [7];
  vn3d_pkg::weight_t sz_q [9];
  always_ff @(posedge clk_i) begin
    sx_q[0] <= sx;
    sy_q[0] <= sy;
    sz_q[0] <= sz;
    for (int i = 1; i < 5; i++) sx_q[i] <= sx_q[i-1];
    for (int i = 1; i < 7; i++) sy_q[i] <= sy_q[i-1];
    for (int i = 1; i < 9; i++) sz_q[i] <= sz_q[i-1];
  end

  vn3d_pkg::val_t lx [4];
  vn3d_pkg::val_t ly [2];
  vn3d_pkg::val_t lz;
  vn3d_pkg::val_t lx_q [4];
  vn3d_pkg::val_t ly_q [2];
  vn3d_pkg::val_t lz_q;

  for (genvar i = 0; i < 4; i++) begin : g_lx
    vn3d_lerp u_lx (.clk_i(clk_i), .p_i(cval[2*i]), .q_i(cval[2*i+1]),
                    .s_i(sx_q[4]), .r_o(lx[i]));
  end
  // blend the two x rows of each z plane along y
  for (genvar i = 0; i < 2; i++) begin : g_ly
    vn3d_lerp u_ly (.clk_i(clk_i), .p_i(lx_q[2*i]), .q_i(lx_q[2*i+1]),
                    .s_i(sy_q[6]), .r_o(ly[i]));
  end
  vn3d_lerp u_lz (.clk_i(clk_i), .p_i(ly_q[0]), .q_i(ly_q[1]),
                  .s_i(sz_q[8]), .r_o(lz));

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) lx_q[i] <= lx[i];
    for (int i = 0; i < 2; i++) ly_q[i] <= ly[i];
    lz_q <= lz;
  end

  assign done_o        = vld_q[Lat-1];
  assign noise_value_o = lz_q;

endmodule
